>>> src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Priority codes, status codes and operation codes used by the cells and top.
// ----------------------------------------------------------------------------
package spq_pkg;

    typedef logic [2:0] t_prio;

    localparam t_prio PRIO_MOST  = 3'd1;
    localparam t_prio PRIO_LEAST = 3'd5;
    localparam t_prio PRIO_EMPTY = 3'd6;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    // Shared control broadcast to every cell in the chain.
    typedef struct packed {
        logic  enq;
        logic  deq;
        t_prio prio;
    } t_cell_ctl;

    function automatic t_prio clamp_prio(input logic [2:0] p);
        t_prio c;
        if (p < PRIO_MOST) begin
            c = PRIO_MOST;
        end else if (p > PRIO_LEAST) begin
            c = PRIO_LEAST;
        end else begin
            c = p;
        end
        return c;
    endfunction

endpackage

>>> src/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds a priority and payload; on enqueue it keeps, takes the new word or
// takes its left neighbor; on dequeue it takes its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int PAYLOAD_WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  spq_pkg::t_cell_ctl       i_ctl,
    input  logic [PAYLOAD_WIDTH-1:0] i_new_payload,
    input  spq_pkg::t_prio           i_left_prio,
    input  logic [PAYLOAD_WIDTH-1:0] i_left_payload,
    input  spq_pkg::t_prio           i_right_prio,
    input  logic [PAYLOAD_WIDTH-1:0] i_right_payload,
    output spq_pkg::t_prio           o_prio,
    output logic [PAYLOAD_WIDTH-1:0] o_payload
);
    import spq_pkg::*;

    t_prio                    r_prio;
    t_prio                    n_prio;
    logic [PAYLOAD_WIDTH-1:0] r_payload;
    logic [PAYLOAD_WIDTH-1:0] n_payload;

    always_comb begin
        n_prio    = r_prio;
        n_payload = r_payload;
        if (i_ctl.enq) begin
            // queue is sorted, so the first cell less urgent than the new
            // entry takes it and every later cell shifts back by one
            if (r_prio > i_ctl.prio) begin
                if (i_left_prio <= i_ctl.prio) begin
                    n_prio    = i_ctl.prio;
                    n_payload = i_new_payload;
                end else begin
                    n_prio    = i_left_prio;
                    n_payload = i_left_payload;
                end
            end
        end else if (i_ctl.deq) begin
            n_prio    = i_right_prio;
            n_payload = i_right_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio <= PRIO_EMPTY;
        end else begin
            r_prio <= n_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_payload <= n_payload;
    end

    assign o_prio    = r_prio;
    assign o_payload = r_payload;

endmodule

>>> src/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: shift-register priority queue
// The result word is registered when the input word is taken.
// One op per cycle unless stalled; every cell compares and shifts at once.
// Reset (synchronous, active low): all slots empty, count zero, no result held.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int DEPTH         = 16,
    parameter int PAYLOAD_WIDTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_operation,
    input  logic [2:0]                   i_priority_req,
    input  logic [PAYLOAD_WIDTH-1:0]     i_payload,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_status,
    output logic [PAYLOAD_WIDTH-1:0]     o_payload_out,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    t_prio                    w_prio    [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] w_payload [DEPTH];
    t_cell_ctl                w_ctl;

    logic                     r_out_valid;
    t_status                  r_status;
    logic [PAYLOAD_WIDTH-1:0] r_payload_out;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    t_status                  n_status;
    logic [PAYLOAD_WIDTH-1:0] n_payload_out;

    logic w_accept;
    logic w_full;
    logic w_empty;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);

    always_comb begin
        w_ctl.enq     = 1'b0;
        w_ctl.deq     = 1'b0;
        w_ctl.prio    = clamp_prio(i_priority_req);
        n_count       = r_count;
        n_status      = ST_OK;
        n_payload_out = '0;
        if (t_op'(i_operation) == OP_ENQ) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                w_ctl.enq = w_accept;
                n_count   = r_count + 1'b1;
            end
        end else begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                w_ctl.deq     = w_accept;
                n_count       = r_count - 1'b1;
                n_payload_out = w_payload[0];
            end
        end
    end

    // edges of the chain: a most urgent phantom on the left, empty on the right
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_prio                    w_lp;
        logic [PAYLOAD_WIDTH-1:0] w_lpay;
        t_prio                    w_rp;
        logic [PAYLOAD_WIDTH-1:0] w_rpay;

        if (k == 0) begin : g_head
            assign w_lp   = PRIO_MOST;
            assign w_lpay = '0;
        end else begin : g_mid_l
            assign w_lp   = w_prio[k-1];
            assign w_lpay = w_payload[k-1];
        end

        if (k == DEPTH - 1) begin : g_tail
            assign w_rp   = PRIO_EMPTY;
            assign w_rpay = '0;
        end else begin : g_mid_r
            assign w_rp   = w_prio[k+1];
            assign w_rpay = w_payload[k+1];
        end

        spq_cell #(
            .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (w_ctl),
            .i_new_payload  (i_payload),
            .i_left_prio    (w_lp),
            .i_left_payload (w_lpay),
            .i_right_prio   (w_rp),
            .i_right_payload(w_rpay),
            .o_prio         (w_prio[k]),
            .o_payload      (w_payload[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (w_accept) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status      <= n_status;
            r_payload_out <= n_payload_out;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_payload_out = r_payload_out;
    assign o_count       = r_count;

endmodule
